FILE: rtl/core/iab_pkg.sv
// ----------------------------------------------------------------------------
// iab_pkg
// Shared widths, codes and reset values of the bitmap index allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package iab_pkg;

   localparam int INDEX_W    = 32;   // index, base and granted index
   localparam int MODE_W     = 3;
   localparam int COUNT_W    = 9;    // slot_count register
   localparam int WORD_BITS  = 32;   // slots per bitmap row
   localparam int BIT_W      = 5;    // log2 of WORD_BITS
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_BASE_INDEX = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SLOT_COUNT = 1'b1;

   localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET = 9'd256;

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC       = 3'd0,
      MODE_CAPTURE     = 3'd1,
      MODE_RELEASE     = 3'd2,
      MODE_QUERY       = 3'd3,
      MODE_RELEASE_ALL = 3'd4
   } mode_type;

endpackage

`default_nettype wire

FILE: rtl/core/iab_if.sv
// ----------------------------------------------------------------------------
// iab_req_if / iab_rsp_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface iab_req_if import iab_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [INDEX_W-1:0] req_index;

   modport source (output valid, mode, req_index, input ready);
   modport sink   (input valid, mode, req_index, output ready);
endinterface

interface iab_rsp_if import iab_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] granted_index;
   logic               success;
   logic               held;

   modport source (output valid, granted_index, success, held, input ready);
   modport sink   (input valid, granted_index, success, held, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/iab_ram.sv
// ----------------------------------------------------------------------------
// iab_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module iab_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/index_allocator_bitmap.sv
// ----------------------------------------------------------------------------
// index_allocator_bitmap
// Next-fit index allocator over a bitmap of occupied slots kept in a RAM of
// 32-bit rows, searched one row per cycle by a shared mask/priority unit.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req_ch   in   valid/ready    mode, req_index
//  rsp_ch   out  valid/ready    granted_index, success, held
//  csr      in   csr_we         csr_index, csr_wdata (no read-back)
//
//  Allocate searches the bitmap row by row from the cursor's row, wrapping
//  at the last live row and revisiting the start row; ROWS = ceil(MAX_SLOTS/32).
//  Capture, release and query read the row, update it, then respond.
//  Release-all clears one row a cycle, then responds.
//  After reset a clearing pass over all ROWS rows runs before req_ch.ready rises.
//  A new request is taken while a response still waits on rsp_ch.
// ----------------------------------------------------------------------------
`default_nettype none

module index_allocator_bitmap import iab_pkg::*; #(
   parameter int MAX_SLOTS = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   iab_req_if.sink                    req_ch,
   iab_rsp_if.source                  rsp_ch,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ROWS  = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SW    = $clog2(MAX_SLOTS);
   localparam logic [RAW-1:0] LAST_ROW = RAW'(ROWS - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_GIVEN,
      S_SEARCH,
      S_RESP
   } state_type;

   state_type              state_ff, state_in;
   logic [INDEX_W-1:0]     base_ff, base_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [SW-1:0]          cursor_ff, cursor_in;
   logic [RAW-1:0]         row_ff, row_in;
   logic [RAW-1:0]         start_row_ff, start_row_in;
   logic [BIT_W-1:0]       bit_ff, bit_in;
   logic                   first_ff, first_in;
   logic                   final_ff, final_in;
   logic                   inrng_ff, inrng_in;
   logic [MODE_W-1:0]      mode_ff, mode_in;
   logic                   clr_req_ff, clr_req_in;
   logic [INDEX_W-1:0]     res_granted_ff, res_granted_in;
   logic                   res_success_ff, res_success_in;
   logic                   res_held_ff, res_held_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]     rsp_granted_ff, rsp_granted_in;
   logic                   rsp_success_ff, rsp_success_in;
   logic                   rsp_held_ff, rsp_held_in;

   logic                   ram_we;
   logic [RAW-1:0]         ram_waddr;
   logic [WORD_BITS-1:0]   ram_wdata;
   logic                   ram_re;
   logic [RAW-1:0]         ram_raddr;
   logic [WORD_BITS-1:0]   ram_rdata;

   logic [31:0]            live32;
   logic [31:0]            off32;
   logic                   in_rng;
   logic [31:0]            lr32;
   logic [BIT_W-1:0]       last_bit;
   logic [31:0]            start32;
   logic [31:0]            row32;
   logic [WORD_BITS-1:0]   live_mask;
   logic [WORD_BITS-1:0]   pass_mask;
   logic [WORD_BITS-1:0]   free_bits;
   logic [BIT_W-1:0]       ff_bit;
   logic                   any_free;
   logic [31:0]            hit_slot32;
   logic [RAW-1:0]         next_row;
   logic [WORD_BITS-1:0]   bit_sel;
   logic                   bit_held;
   logic                   rsp_load;

   iab_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (ROWS),
      .ADDR_W(RAW)
   ) u_bitmap (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // live count, window offset and search bounds
   always_comb begin
      if (count_ff == '0) begin
         live32 = 32'd1;
      end else if (32'(count_ff) > 32'(MAX_SLOTS)) begin
         live32 = 32'(MAX_SLOTS);
      end else begin
         live32 = 32'(count_ff);
      end
      off32    = req_ch.req_index - base_ff;
      in_rng   = off32 < live32;
      lr32     = (live32 - 32'd1) >> BIT_W;
      last_bit = BIT_W'(live32 - 32'd1);
      start32  = (32'(cursor_ff) < live32) ? 32'(cursor_ff) : 32'd0;
      row32    = 32'(row_ff);
   end

   // shared row unit: mask, find first free slot
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         if (row32 < lr32) begin
            live_mask[b] = 1'b1;
         end else if (row32 == lr32) begin
            live_mask[b] = BIT_W'(b) <= last_bit;
         end else begin
            live_mask[b] = 1'b0;
         end
         if (first_ff) begin
            pass_mask[b] = BIT_W'(b) >= bit_ff;
         end else if (final_ff) begin
            pass_mask[b] = BIT_W'(b) < bit_ff;
         end else begin
            pass_mask[b] = 1'b1;
         end
      end
      free_bits = ~ram_rdata & live_mask & pass_mask;
      any_free  = |free_bits;
      ff_bit    = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            ff_bit = BIT_W'(b);
         end
      end
      hit_slot32 = (row32 << BIT_W) | 32'(ff_bit);
      next_row   = (row32 == lr32) ? '0 : RAW'(row32 + 32'd1);
      bit_sel    = WORD_BITS'(1) << bit_ff;
      bit_held   = |(ram_rdata & bit_sel);
   end

   assign req_ch.ready         = (state_ff == S_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.granted_index = rsp_granted_ff;
   assign rsp_ch.success       = rsp_success_ff;
   assign rsp_ch.held          = rsp_held_ff;

   always_comb begin
      state_in       = state_ff;
      base_in        = base_ff;
      count_in       = count_ff;
      cursor_in      = cursor_ff;
      row_in         = row_ff;
      start_row_in   = start_row_ff;
      bit_in         = bit_ff;
      first_in       = first_ff;
      final_in       = final_ff;
      inrng_in       = inrng_ff;
      mode_in        = mode_ff;
      clr_req_in     = clr_req_ff;
      res_granted_in = res_granted_ff;
      res_success_in = res_success_ff;
      res_held_in    = res_held_ff;
      ram_we         = 1'b0;
      ram_waddr      = row_ff;
      ram_wdata      = ram_rdata;
      ram_re         = 1'b0;
      ram_raddr      = row_ff;
      rsp_load       = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_BASE_INDEX: base_in  = csr_wdata;
            CSR_SLOT_COUNT: count_in = csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = row_ff;
            ram_wdata = '0;
            row_in    = row_ff + RAW'(1);
            if (row_ff == LAST_ROW) begin
               state_in = clr_req_ff ? S_RESP : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               mode_in        = req_ch.mode;
               res_granted_in = '0;
               res_success_in = 1'b0;
               res_held_in    = 1'b0;
               case (mode_type'(req_ch.mode))
                  MODE_ALLOC: begin
                     row_in       = RAW'(start32 >> BIT_W);
                     start_row_in = RAW'(start32 >> BIT_W);
                     bit_in       = BIT_W'(start32);
                     first_in     = 1'b1;
                     final_in     = 1'b0;
                     ram_re       = 1'b1;
                     ram_raddr    = RAW'(start32 >> BIT_W);
                     state_in     = S_SEARCH;
                  end
                  MODE_CAPTURE, MODE_RELEASE, MODE_QUERY: begin
                     row_in    = RAW'(off32 >> BIT_W);
                     bit_in    = BIT_W'(off32);
                     inrng_in  = in_rng;
                     ram_re    = in_rng;
                     ram_raddr = RAW'(off32 >> BIT_W);
                     state_in  = S_GIVEN;
                  end
                  MODE_RELEASE_ALL: begin
                     row_in         = '0;
                     clr_req_in     = 1'b1;
                     res_success_in = 1'b1;
                     state_in       = S_CLEAR;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_GIVEN: begin
            state_in = S_RESP;
            if (inrng_ff) begin
               case (mode_type'(mode_ff))
                  MODE_CAPTURE: begin
                     if (!bit_held) begin
                        ram_we         = 1'b1;
                        ram_wdata      = ram_rdata | bit_sel;
                        res_success_in = 1'b1;
                     end
                  end
                  MODE_RELEASE: begin
                     ram_we         = 1'b1;
                     ram_wdata      = ram_rdata & ~bit_sel;
                     res_success_in = 1'b1;
                  end
                  MODE_QUERY: begin
                     res_held_in = bit_held;
                  end
                  default: ;
               endcase
            end
         end
         S_SEARCH: begin
            first_in = 1'b0;
            if (any_free) begin
               ram_we         = 1'b1;
               ram_wdata      = ram_rdata | (WORD_BITS'(1) << ff_bit);
               cursor_in      = SW'(hit_slot32);
               res_granted_in = base_ff + hit_slot32;
               res_success_in = 1'b1;
               state_in       = S_RESP;
            end else if (final_ff) begin
               // every live slot full: leave bits and cursor alone
               state_in = S_RESP;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = next_row;
               row_in    = next_row;
               final_in  = (next_row == start_row_ff);
            end
         end
         S_RESP: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load   = 1'b1;
               clr_req_in = 1'b0;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_granted_in = res_granted_ff;
         rsp_success_in = res_success_ff;
         rsp_held_in    = res_held_ff;
      end else begin
         rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
         rsp_granted_in = rsp_granted_ff;
         rsp_success_in = rsp_success_ff;
         rsp_held_in    = rsp_held_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         base_ff      <= '0;
         count_ff     <= SLOT_COUNT_RESET;
         cursor_ff    <= '0;
         row_ff       <= '0;
         first_ff     <= 1'b0;
         final_ff     <= 1'b0;
         clr_req_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         row_ff       <= row_in;
         first_ff     <= first_in;
         final_ff     <= final_in;
         clr_req_ff   <= clr_req_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      start_row_ff   <= start_row_in;
      bit_ff         <= bit_in;
      inrng_ff       <= inrng_in;
      mode_ff        <= mode_in;
      res_granted_ff <= res_granted_in;
      res_success_ff <= res_success_in;
      res_held_ff    <= res_held_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_success_ff <= rsp_success_in;
      rsp_held_ff    <= rsp_held_in;
   end

endmodule

`default_nettype wire
